// ----- rtl/cmean_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cmean_pkg;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_REPORT = 2'd2
  } cmd_e;

  // Quarter-wave sine table, round(32767 * sin(k * 0.1 deg)) for k = 0..900
  localparam int QSINE_DEPTH = 901;
  localparam int QIDX_W      = 10;
  localparam int QVAL_W      = 15;
  typedef logic [QVAL_W-1:0] qsine_tab_t [QSINE_DEPTH];

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;
  localparam longint unsigned TAYLOR_DIV [9] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
  };

  // Q30 Taylor series, evaluated at elaboration only
  function automatic qsine_tab_t build_qsine();
    qsine_tab_t tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned acc;
    longint unsigned rnd;
    for (int k = 0; k < QSINE_DEPTH; k++) begin
      x    = (longint'(k) * PI_Q30) / 1800;
      x2   = (x * x) >> 30;
      term = x;
      acc  = x;
      for (int n = 1; n <= 9; n++) begin
        term = (term * x2) >> 30;
        term = term / TAYLOR_DIV[n-1];
        if ((n & 1) == 1) acc = acc - term;
        else              acc = acc + term;
      end
      if (acc > ONE_Q30) acc = ONE_Q30;
      rnd    = (acc * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
      tab[k] = rnd[QVAL_W-1:0];
    end
    return tab;
  endfunction

  localparam qsine_tab_t QSINE = build_qsine();

  // CORDIC datapath
  localparam int XY_W  = 33;
  localparam int ANG_W = 21;
  localparam logic signed [XY_W-1:0] PRESCALE_LIM = 33'sd67108864;  // 2^26
  localparam logic signed [16:0] ATAN_MDEG [16] = '{
    17'sd45000, 17'sd26565, 17'sd14036, 17'sd7125, 17'sd3576, 17'sd1790,
    17'sd895,   17'sd448,   17'sd224,   17'sd112,  17'sd56,   17'sd28,
    17'sd14,    17'sd7,     17'sd3,     17'sd2
  };
  localparam logic signed [ANG_W-1:0] HALF_TURN_MDEG = 21'sd180000;
  localparam logic signed [ANG_W-1:0] FULL_TURN_MDEG = 21'sd360000;

  // floor(v / 100) = (v * RECIP_100) >> RECIP_SHIFT for v < 493499
  localparam logic [18:0] RECIP_100   = 19'd335545;
  localparam int          RECIP_SHIFT = 25;
  localparam logic [18:0] ROUND_HALF  = 19'd50;
  localparam logic [11:0] TENTHS_FULL = 12'd3600;

endpackage

`default_nettype wire

// ----- rtl/cmean_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface cmean_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [11:0] angle_tenths;

  modport source (output valid, cmd, angle_tenths, input ready);
  modport sink   (input valid, cmd, angle_tenths, output ready);
endinterface

`default_nettype wire

// ----- rtl/cmean_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface cmean_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] mean_tenths;
  logic        no_samples;

  modport source (output valid, mean_tenths, no_samples, input ready);
  modport sink   (input valid, mean_tenths, no_samples, output ready);
endinterface

`default_nettype wire

// ----- rtl/circular_mean_of_angles_core.sv -----
// Circular mean of direction angles (tenths of a degree).
// req channel: one word per command. cmd add accumulates sin/cos of angle_tenths
// (taken modulo 3600), clear zeroes sums and count, report returns one word on
// rsp. Unused cmd codes are dropped. Adds beyond SAMPLE_LIMIT are dropped.
// req.ready is high only while the sequencer is idle; one word at a time.
// Add: two reads of the shared quarter-sine ROM port, one per sum.
// Clear: applied on acceptance; the sequencer stays idle.
// Report: a prescale step that shifts both sums right while either is too large,
// CORDIC_STEPS iterations of the shared shift/add unit, then wrap, scale-by-1/100
// and load. A zero vector skips prescale and the iterations; an empty report
// (no samples) goes straight to load.
// rsp is an output register: adds and clears keep flowing while a result
// waits; a report finishing while rsp is stalled holds in its last state.
// Reset (rst, synchronous) clears sums, count, sequencer and rsp.valid.
`timescale 1ns / 1ps
`default_nettype none

module circular_mean_of_angles_core #(
  parameter int SAMPLE_LIMIT = 65535,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  cmean_in_if.sink    req,
  cmean_out_if.source rsp
);
  import cmean_pkg::*;

  localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_ADD_SIN  = 8'b0000_0010,
    S_ADD_COS  = 8'b0000_0100,
    S_PRESCALE = 8'b0000_1000,
    S_ROTATE   = 8'b0001_0000,
    S_WRAP     = 8'b0010_0000,
    S_SCALE    = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  // {negate, table index}
  function automatic logic [QIDX_W:0] fold(input logic [11:0] a);
    logic [11:0] r;
    logic        mirror;
    logic        neg;
    logic [11:0] idx;
    if (a < 12'd900) begin
      r = a;            mirror = 1'b0; neg = 1'b0;
    end else if (a < 12'd1800) begin
      r = a - 12'd900;  mirror = 1'b1; neg = 1'b0;
    end else if (a < 12'd2700) begin
      r = a - 12'd1800; mirror = 1'b0; neg = 1'b1;
    end else begin
      r = a - 12'd2700; mirror = 1'b1; neg = 1'b1;
    end
    idx = mirror ? (12'd900 - r) : r;
    return {neg, idx[QIDX_W-1:0]};
  endfunction

  state_t                   state;
  logic [11:0]              angle;
  logic [QVAL_W-1:0]        rom_q;
  logic                     rom_neg;
  logic [31:0]              sine_sum;
  logic [31:0]              cosine_sum;
  logic [15:0]              sample_count;
  logic signed [XY_W-1:0]   x;
  logic signed [XY_W-1:0]   y;
  logic signed [ANG_W-1:0]  ang;
  logic                     flip;
  logic                     empty;
  logic [STEP_W-1:0]        step;
  logic [36:0]              prod;
  logic                     out_valid;
  logic [11:0]              out_mean;
  logic                     out_empty;

  logic                     accept;
  logic [11:0]              angle_mod;
  logic [11:0]              cos_angle;
  logic [QIDX_W:0]          fold_sel;
  logic [31:0]              term;
  logic signed [XY_W-1:0]   sin_s;
  logic signed [XY_W-1:0]   cos_s;
  logic signed [XY_W-1:0]   xs;
  logic signed [XY_W-1:0]   ys;
  logic signed [ANG_W-1:0]  atan_step;
  logic signed [ANG_W-1:0]  ang_flip;
  logic signed [ANG_W-1:0]  ang_wrap;
  logic [18:0]              round_in;
  logic [11:0]              quot;
  logic                     big;

  assign req.ready     = (state == S_IDLE);
  assign accept        = req.valid && req.ready;
  assign rsp.valid     = out_valid;
  assign rsp.mean_tenths = out_mean;
  assign rsp.no_samples  = out_empty;

  assign angle_mod = (req.angle_tenths >= TENTHS_FULL) ? req.angle_tenths - TENTHS_FULL
                                                       : req.angle_tenths;
  assign cos_angle = (angle >= 12'd2700) ? angle - 12'd2700 : angle + 12'd900;
  // one ROM port: sine address at accept, cosine address in the next cycle
  assign fold_sel  = (state == S_ADD_SIN) ? fold(cos_angle) : fold(angle_mod);
  assign term      = rom_neg ? -{17'b0, rom_q} : {17'b0, rom_q};

  assign sin_s = {sine_sum[31], sine_sum};
  assign cos_s = {cosine_sum[31], cosine_sum};
  assign big   = (x >= PRESCALE_LIM) || (y >= PRESCALE_LIM) || (y <= -PRESCALE_LIM);

  assign xs        = x >>> step;
  assign ys        = y >>> step;
  assign atan_step = ANG_W'(ATAN_MDEG[4'(step)]);

  assign ang_flip = flip ? ang + HALF_TURN_MDEG : ang;
  assign ang_wrap = (ang_flip < 0) ? ang_flip + FULL_TURN_MDEG : ang_flip;
  assign round_in = ang[18:0] + ROUND_HALF;
  assign quot     = prod[36:RECIP_SHIFT];

  always_ff @(posedge clk) begin
    rom_q   <= QSINE[fold_sel[QIDX_W-1:0]];
    rom_neg <= fold_sel[QIDX_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sine_sum     <= '0;
      cosine_sum   <= '0;
      sample_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      // S_DONE owns out_valid while it is loading the next word
      if (out_valid && rsp.ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (cmd_e'(req.cmd))
              CMD_ADD: begin
                if (sample_count < 16'(SAMPLE_LIMIT)) begin
                  sample_count <= sample_count + 16'd1;
                  angle        <= angle_mod;
                  state        <= S_ADD_SIN;
                end
              end
              CMD_CLEAR: begin
                sine_sum     <= '0;
                cosine_sum   <= '0;
                sample_count <= '0;
              end
              CMD_REPORT: begin
                // fold into the right half-plane
                flip  <= cos_s < 0;
                x     <= (cos_s < 0) ? -cos_s : cos_s;
                y     <= (cos_s < 0) ? -sin_s : sin_s;
                ang   <= '0;
                step  <= '0;
                empty <= (sample_count == 16'd0);
                if (sample_count == 16'd0)
                  state <= S_DONE;
                else if (sine_sum == 32'd0 && cosine_sum == 32'd0)
                  state <= S_WRAP;
                else
                  state <= S_PRESCALE;
              end
              default: ;
            endcase
          end
        end
        S_ADD_SIN: begin
          sine_sum <= sine_sum + term;
          state    <= S_ADD_COS;
        end
        S_ADD_COS: begin
          cosine_sum <= cosine_sum + term;
          state      <= S_IDLE;
        end
        S_PRESCALE: begin
          if (big) begin
            x <= x >>> 1;
            y <= y >>> 1;
          end else begin
            state <= S_ROTATE;
          end
        end
        S_ROTATE: begin
          if (y > 0) begin
            x   <= x + ys;
            y   <= y - xs;
            ang <= ang + atan_step;
          end else begin
            x   <= x - ys;
            y   <= y + xs;
            ang <= ang - atan_step;
          end
          step <= step + STEP_W'(1);
          if (step == STEP_W'(CORDIC_STEPS - 1)) state <= S_WRAP;
        end
        S_WRAP: begin
          ang   <= ang_wrap;
          state <= S_SCALE;
        end
        S_SCALE: begin
          prod  <= 37'(round_in) * 37'(RECIP_100);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_empty <= empty;
            out_mean  <= (empty || quot == TENTHS_FULL) ? 12'd0 : quot;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cmean_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cmean_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic [1:0]  req_cmd,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [11:0] rsp_mean_tenths,
  input wire logic        rsp_no_samples
);
  import cmean_pkg::*;

  // a taken report leaves the sequencer busy, so ready is low after it
  a_report_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_cmd == CMD_REPORT |=> !req_ready)
    else $error("ready high right after a report was taken");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_no_samples |-> rsp_mean_tenths == 12'd0)
    else $error("empty report with nonzero mean");

  a_mean_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_mean_tenths < TENTHS_FULL)
    else $error("mean out of range");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mean_tenths)
                                && $stable(rsp_no_samples))
    else $error("stalled result word changed");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result valid right after reset");

endmodule

bind circular_mean_of_angles_core cmean_chk u_chk (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .req_cmd         (req.cmd),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_mean_tenths (rsp.mean_tenths),
  .rsp_no_samples  (rsp.no_samples)
);

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import cmean_pkg::*;

  localparam int SAMPLE_CAP     = 65535;
  localparam int CORDIC_ITERS   = 16;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_WORDS   = 1300;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam longint unsigned Q30_PI  = 64'd3373259426;
  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint SHIFT_DOWN_LIM   = 64'sd67108864;
  localparam longint HALF_TURN        = 64'sd180000;
  localparam longint FULL_TURN        = 64'sd360000;
  localparam longint ARCTAN_MDEG [16] = '{
    45000, 26565, 14036, 7125, 3576, 1790, 895, 448, 224, 112, 56, 28, 14, 7, 3, 2
  };

  typedef struct packed {
    logic [11:0] mean;
    logic        empty;
  } heading_t;

  class direction_averager;
    bit [31:0]       sin_acc;
    bit [31:0]       cos_acc;
    bit [15:0]       n_samples;
    longint unsigned quarter_wave [901];
    heading_t        expected_headings [$];
    int unsigned     mismatches;

    function new();
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned acc;
      longint unsigned kk;
      for (int k = 0; k <= 900; k++) begin
        kk   = k;
        x    = (kk * Q30_PI) / 1800;
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        for (int n = 1; n <= 9; n++) begin
          term = (term * x2) >> 30;
          term = term / ((2 * n) * (2 * n + 1));
          if (n % 2 == 1) acc = acc - term;
          else acc = acc + term;
        end
        if (acc > Q30_ONE) acc = Q30_ONE;
        quarter_wave[k] = (acc * 32767 + (Q30_ONE >> 1)) >> 30;
      end
      mismatches = 0;
      sin_acc    = 0;
      cos_acc    = 0;
      n_samples  = 0;
    endfunction

    function longint sine_q15(int unsigned a);
      int unsigned quad;
      int unsigned rem;
      quad = a / 900;
      rem  = a % 900;
      case (quad)
        0: return longint'(quarter_wave[rem]);
        1: return longint'(quarter_wave[900 - rem]);
        2: return -longint'(quarter_wave[rem]);
        default: return -longint'(quarter_wave[900 - rem]);
      endcase
    endfunction

    // vectoring CORDIC in millidegrees, after folding into the right half-plane
    function longint direction_mdeg(longint y, longint x);
      longint ang;
      longint xs;
      longint ys;
      bit     flip;
      ang  = 0;
      flip = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        x    = -x;
        y    = -y;
        flip = 1;
      end
      while (x >= SHIFT_DOWN_LIM || y >= SHIFT_DOWN_LIM || y <= -SHIFT_DOWN_LIM) begin
        x = x >>> 1;
        y = y >>> 1;
      end
      for (int i = 0; i < CORDIC_ITERS && i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x   = x + ys;
          y   = y - xs;
          ang = ang + ARCTAN_MDEG[i];
        end else begin
          x   = x - ys;
          y   = y + xs;
          ang = ang - ARCTAN_MDEG[i];
        end
      end
      if (flip) ang = ang + HALF_TURN;
      ang = ang % FULL_TURN;
      if (ang < 0) ang = ang + FULL_TURN;
      return ang;
    endfunction

    function void note_command(logic [1:0] cmd, logic [11:0] angle);
      int unsigned a;
      longint      mdeg;
      heading_t    h;
      a = angle % 3600;
      if (cmd == CMD_ADD) begin
        if (n_samples < SAMPLE_CAP) begin
          sin_acc   = sin_acc + 32'(sine_q15(a));
          cos_acc   = cos_acc + 32'(sine_q15((a + 900) % 3600));
          n_samples = n_samples + 1;
        end
      end else if (cmd == CMD_CLEAR) begin
        sin_acc   = 0;
        cos_acc   = 0;
        n_samples = 0;
      end else if (cmd == CMD_REPORT) begin
        if (n_samples == 0) begin
          h.mean  = 0;
          h.empty = 1'b1;
        end else begin
          mdeg    = direction_mdeg(longint'($signed(sin_acc)), longint'($signed(cos_acc)));
          h.mean  = 12'(((mdeg + 50) / 100) % 3600);
          h.empty = 1'b0;
        end
        expected_headings.push_back(h);
      end
    endfunction

    function void check_report(logic [11:0] mean, logic empty);
      heading_t h;
      if (expected_headings.size() == 0) begin
        $error("result word with none expected: mean_tenths %0d no_samples %0d", mean, empty);
        mismatches++;
        return;
      end
      h = expected_headings.pop_front();
      if (mean !== h.mean) begin
        $error("mean_tenths: expected %0d, actual %0d", h.mean, mean);
        mismatches++;
      end
      if (empty !== h.empty) begin
        $error("no_samples: expected %0d, actual %0d", h.empty, empty);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_headings.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  cmean_in_if  req_if ();
  cmean_out_if rsp_if ();

  circular_mean_of_angles_core #(
    .SAMPLE_LIMIT(SAMPLE_CAP),
    .CORDIC_STEPS(CORDIC_ITERS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  always #2 clk = ~clk;

  direction_averager averager = new();

  int          send_idle_pct;
  int          recv_idle_pct;
  int unsigned hold_requests;
  int unsigned words_sent;
  int unsigned idle_cycles;

  // one command word; waits for acceptance, leaves valid up for the next word
  task automatic send_word(input logic [1:0] c, input logic [11:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid        <= 1'b0;
      req_if.cmd          <= 2'($urandom);
      req_if.angle_tenths <= 12'($urandom);
      @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.cmd          <= c;
    req_if.angle_tenths <= a;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    averager.note_command(c, a);
    if (c != CMD_UNUSED) words_sent++;
  endtask

  // an optional clear, a run of adds around one heading (with an occasional random word), then a report
  task automatic send_cluster();
    int unsigned centre;
    int unsigned spread;
    int unsigned n;
    int unsigned a;
    if ($urandom_range(3) == 0) send_word(CMD_CLEAR, 12'($urandom));
    centre = $urandom_range(3599);
    case ($urandom_range(3))
      0: spread = 0;
      1: spread = $urandom_range(60);
      2: spread = $urandom_range(900);
      default: spread = 1800;
    endcase
    n = $urandom_range(1, 12);
    repeat (n) begin
      a = (centre + 3600 - spread + $urandom_range(2 * spread)) % 3600;
      if (a < 496 && $urandom_range(1) == 1) a = a + 3600;
      send_word(CMD_ADD, 12'(a));
      if ($urandom_range(19) == 0) send_word(2'($urandom), 12'($urandom));
    end
    send_word(CMD_REPORT, 12'($urandom));
  endtask

  task automatic run_random(input int unsigned target);
    while (words_sent < target) begin
      if ($urandom_range(9) < 8) send_cluster();
      else send_word(2'($urandom), 12'($urandom));
    end
  endtask

  // receiver: checks result words, random stalls, long hold-offs on request
  initial begin
    int unsigned hold_served;
    int unsigned stall_left;
    hold_served = 0;
    stall_left  = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_if.valid && rsp_if.ready)
        averager.check_report(rsp_if.mean_tenths, rsp_if.no_samples);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        stall_left  = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    rst                 <= 1'b1;
    req_if.valid        <= 1'b0;
    req_if.cmd          <= CMD_ADD;
    req_if.angle_tenths <= 12'd0;
    hold_requests       <= 0;
    words_sent    = 0;
    send_idle_pct = 35;
    recv_idle_pct = 52;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty, zero vector, quadrant edges, out-of-range angles, unused code
    send_word(CMD_REPORT, 12'd4095);
    send_word(CMD_ADD, 12'd0);
    send_word(CMD_REPORT, 12'd0);
    send_word(CMD_ADD, 12'd1800);
    send_word(CMD_REPORT, 12'd1800);
    send_word(CMD_CLEAR, 12'd4095);
    send_word(CMD_REPORT, 12'd0);
    send_word(CMD_ADD, 12'd900);
    send_word(CMD_REPORT, 12'd0);
    send_word(CMD_ADD, 12'd3599);
    send_word(CMD_ADD, 12'd4095);
    send_word(CMD_ADD, 12'd2700);
    send_word(CMD_ADD, 12'd899);
    send_word(CMD_ADD, 12'd901);
    send_word(CMD_REPORT, 12'd2048);
    send_word(CMD_UNUSED, 12'd4095);
    send_word(CMD_UNUSED, 12'd0);
    send_word(CMD_REPORT, 12'd0);
    send_word(CMD_CLEAR, 12'd0);
    send_word(CMD_ADD, 12'd3600);
    send_word(CMD_ADD, 12'd2699);
    send_word(CMD_REPORT, 12'd3599);
    run_random(RANDOM_WORDS / 3);

    send_idle_pct = 52;
    recv_idle_pct = 35;
    // result path held off: second report backs up into the request side
    hold_requests <= hold_requests + 1;
    send_word(CMD_REPORT, 12'd0);
    repeat (3) send_word(CMD_ADD, 12'($urandom));
    send_word(CMD_REPORT, 12'd0);
    repeat (3) send_word(CMD_ADD, 12'($urandom));
    send_word(CMD_REPORT, 12'd0);
    run_random(2 * RANDOM_WORDS / 3);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(RANDOM_WORDS);

    send_word(CMD_CLEAR, 12'd0);
    send_word(CMD_ADD, 12'd1800);
    send_word(CMD_REPORT, 12'd0);
    send_word(CMD_CLEAR, 12'd0);
    send_word(CMD_REPORT, 12'd0);
    req_if.valid <= 1'b0;

    while (averager.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (averager.mismatches == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule
